// ===== src/svc_pkg.sv =====
// Shared types and constants of the sprite viewport clipper.
`default_nettype none
package svc_pkg;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 160;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned NUM_STAGES = 5;

  localparam logic [11:0] VP_WIDTH_RST  = 12'd480;
  localparam logic [11:0] VP_HEIGHT_RST = 12'd272;
  localparam logic [12:0] PITCH_RST     = 13'd480;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_VP_W     = 3'd3,
    REG_VP_H     = 3'd4,
    REG_CAMERA_X = 3'd5,
    REG_CAMERA_Y = 3'd6,
    REG_PITCH    = 3'd7
  } svc_reg_t;

  typedef struct packed {
    logic        enable;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] vp_width;
    logic [11:0] vp_height;
    logic [15:0] camera_x;
    logic [15:0] camera_y;
    logic [12:0] pitch;
  } svc_cfg_t;

  typedef struct packed {
    logic [12:0] sheet_width;
    logic [10:0] frame_height;
    logic [10:0] frame_width;
    logic [7:0]  frame_row;
    logic [7:0]  frame_column;
    logic [15:0] world_y;
    logic [15:0] world_x;
  } svc_item_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [15:0] ofx;
    logic [15:0] ofy;
    logic [12:0] sw;
  } svc_rel_t;

  typedef struct packed {
    logic        vis;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] ofx;
    logic [15:0] ofy;
    logic [12:0] sw;
  } svc_clip_t;

  typedef struct packed {
    logic        draw;
    logic [15:0] dest_left;
    logic [15:0] dest_top;
    logic [12:0] clip_width;
    logic [12:0] clip_height;
    logic [15:0] sheet_x;
    logic [15:0] sheet_y;
    logic [31:0] source_index;
    logic [31:0] dest_index;
  } svc_res_t;

endpackage
`default_nettype wire

// ===== src/svc_regs.sv =====
// Viewport configuration registers behind the APB-style port.
`default_nettype none
module svc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [svc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output svc_pkg::svc_cfg_t               cfg
);
  import svc_pkg::*;

  svc_cfg_t cfg_r;
  svc_reg_t idx;
  logic     wr_en;

  assign idx    = svc_reg_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.origin_x  <= '0;
      cfg_r.origin_y  <= '0;
      cfg_r.vp_width  <= VP_WIDTH_RST;
      cfg_r.vp_height <= VP_HEIGHT_RST;
      cfg_r.camera_x  <= '0;
      cfg_r.camera_y  <= '0;
      cfg_r.pitch     <= PITCH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE:   cfg_r.enable    <= pwdata[0];
        REG_ORIGIN_X: cfg_r.origin_x  <= pwdata[11:0];
        REG_ORIGIN_Y: cfg_r.origin_y  <= pwdata[11:0];
        REG_VP_W:     cfg_r.vp_width  <= pwdata[11:0];
        REG_VP_H:     cfg_r.vp_height <= pwdata[11:0];
        REG_CAMERA_X: cfg_r.camera_x  <= pwdata[15:0];
        REG_CAMERA_Y: cfg_r.camera_y  <= pwdata[15:0];
        REG_PITCH:    cfg_r.pitch     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:   prdata = {31'd0, cfg_r.enable};
      REG_ORIGIN_X: prdata = {20'd0, cfg_r.origin_x};
      REG_ORIGIN_Y: prdata = {20'd0, cfg_r.origin_y};
      REG_VP_W:     prdata = {20'd0, cfg_r.vp_width};
      REG_VP_H:     prdata = {20'd0, cfg_r.vp_height};
      REG_CAMERA_X: prdata = {16'd0, cfg_r.camera_x};
      REG_CAMERA_Y: prdata = {16'd0, cfg_r.camera_y};
      REG_PITCH:    prdata = {19'd0, cfg_r.pitch};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/svc_offset.sv =====
// Camera-relative edges and sheet frame offsets, two register stages.
`default_nettype none
module svc_offset (
  input  wire logic               clk,
  input  wire logic               en1,
  input  wire logic               en2,
  input  wire svc_pkg::svc_item_t item,
  input  wire svc_pkg::svc_cfg_t  cfg,
  output svc_pkg::svc_rel_t       rel
);
  import svc_pkg::*;

  logic [15:0] a_r, b_r, ofx_r, ofy_r;
  logic [10:0] fw_r, fh_r;
  logic [12:0] sw1_r;
  logic [18:0] mul_x, mul_y;
  svc_rel_t    rel_r;

  assign mul_x = 19'(item.frame_column) * 19'(item.frame_width);
  assign mul_y = 19'(item.frame_row) * 19'(item.frame_height);

  always_ff @(posedge clk) begin
    if (en1) begin
      a_r   <= item.world_x - cfg.camera_x;
      b_r   <= item.world_y - cfg.camera_y;
      ofx_r <= mul_x[15:0];
      ofy_r <= mul_y[15:0];
      fw_r  <= item.frame_width;
      fh_r  <= item.frame_height;
      sw1_r <= item.sheet_width;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      rel_r.a   <= a_r;
      rel_r.b   <= b_r;
      rel_r.c   <= a_r + {5'd0, fw_r};
      rel_r.d   <= b_r + {5'd0, fh_r};
      rel_r.ofx <= ofx_r;
      rel_r.ofy <= ofy_r;
      rel_r.sw  <= sw1_r;
    end
  end

  assign rel = rel_r;

endmodule
`default_nettype wire

// ===== src/svc_clip.sv =====
// Visibility test and edge clipping against the viewport, one register stage.
`default_nettype none
module svc_clip (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire svc_pkg::svc_rel_t rel,
  input  wire svc_pkg::svc_cfg_t cfg,
  output svc_pkg::svc_clip_t     clip
);
  import svc_pkg::*;

  logic signed [15:0] as, bs, cs, ds, qs, rs, xs, ys, us, vs;
  logic signed [15:0] ad, bd, cd, dd;
  logic [12:0]        u_sum, v_sum;
  logic               a_in, b_in, c_in, d_in, vis;
  logic               clip_l, clip_t;
  svc_clip_t          clip_r;

  assign as = $signed(rel.a);
  assign bs = $signed(rel.b);
  assign cs = $signed(rel.c);
  assign ds = $signed(rel.d);
  assign qs = $signed({4'd0, cfg.vp_width});
  assign rs = $signed({4'd0, cfg.vp_height});
  assign xs = $signed({4'd0, cfg.origin_x});
  assign ys = $signed({4'd0, cfg.origin_y});

  assign u_sum = {1'b0, cfg.vp_width} + {1'b0, cfg.origin_x};
  assign v_sum = {1'b0, cfg.vp_height} + {1'b0, cfg.origin_y};
  assign us    = $signed({3'd0, u_sum});
  assign vs    = $signed({3'd0, v_sum});

  assign a_in = (as >= 16'sd0) && (as <= qs);
  assign c_in = (cs >= 16'sd0) && (cs <= qs);
  assign b_in = (bs >= 16'sd0) && (bs <= rs);
  assign d_in = (ds >= 16'sd0) && (ds <= rs);

  assign vis = ((a_in || c_in) && (bs <= 16'sd0) && (ds >= rs))
            || ((cs >= qs) && (as <= 16'sd0) && (b_in || d_in))
            || ((a_in || c_in) && (b_in || d_in));

  assign ad = as + xs;
  assign bd = bs + ys;
  assign cd = cs + xs;
  assign dd = ds + ys;

  assign clip_l = ad < xs;
  assign clip_t = bd < ys;

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r.vis    <= vis;
      clip_r.left   <= clip_l ? xs : ad;
      clip_r.top    <= clip_t ? ys : bd;
      clip_r.right  <= (cd > us) ? us : cd;
      clip_r.bottom <= (dd > vs) ? vs : dd;
      clip_r.ofx    <= clip_l ? rel.ofx - rel.a : rel.ofx;
      clip_r.ofy    <= clip_t ? rel.ofy - rel.b : rel.ofy;
      clip_r.sw     <= rel.sw;
    end
  end

  assign clip = clip_r;

endmodule
`default_nettype wire

// ===== src/svc_index.sv =====
// Clipped size, draw decision and pixel indices, two register stages.
`default_nettype none
module svc_index (
  input  wire logic               clk,
  input  wire logic               en4,
  input  wire logic               en5,
  input  wire svc_pkg::svc_clip_t clip,
  input  wire svc_pkg::svc_cfg_t  cfg,
  output svc_pkg::svc_res_t       res
);
  import svc_pkg::*;

  logic [15:0] w, h;
  logic        draw;
  logic        draw_r;
  logic [15:0] left_r, top_r, sx_r, sy_r;
  logic [12:0] cw_r, ch_r;
  logic [28:0] src_mul_r, dst_mul_r;
  svc_res_t    res_r;

  assign w    = clip.right - clip.left;
  assign h    = clip.bottom - clip.top;
  assign draw = cfg.enable && clip.vis && !w[15] && (w != '0) && !h[15] && (h != '0);

  always_ff @(posedge clk) begin
    if (en4) begin
      draw_r    <= draw;
      left_r    <= draw ? clip.left : '0;
      top_r     <= draw ? clip.top : '0;
      cw_r      <= draw ? w[12:0] : '0;
      ch_r      <= draw ? h[12:0] : '0;
      sx_r      <= draw ? clip.ofx : '0;
      sy_r      <= draw ? clip.ofy : '0;
      src_mul_r <= draw ? 29'(clip.ofy) * 29'(clip.sw) : '0;
      dst_mul_r <= draw ? 29'(clip.top) * 29'(cfg.pitch) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      res_r.draw         <= draw_r;
      res_r.dest_left    <= left_r;
      res_r.dest_top     <= top_r;
      res_r.clip_width   <= cw_r;
      res_r.clip_height  <= ch_r;
      res_r.sheet_x      <= sx_r;
      res_r.sheet_y      <= sy_r;
      res_r.source_index <= 32'(src_mul_r) + 32'(sx_r);
      res_r.dest_index   <= 32'(dst_mul_r) + 32'(left_r);
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== src/sprite_viewport_clipper.sv =====
// Top level of the sprite viewport clipper: stream ports, stage control, APB registers.
// Throughput: one request per cycle while the output is not stalled; five register stages, each with its own valid bit.
// A stalled output holds the pipeline; empty stages still fill behind it.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
`default_nettype none
module sprite_viewport_clipper (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // world_x, world_y, frame_column, frame_row, frame_width, frame_height, sheet_width
  input  wire logic [svc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // dest_left, dest_top, clip_width, clip_height, sheet_x, sheet_y,
  // source_index, dest_index
  output logic      [svc_pkg::OUT_DATA_W-1:0] out_tdata,
  // draw
  output logic                                out_tuser,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [svc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import svc_pkg::*;

  svc_cfg_t                cfg;
  svc_item_t               item;
  svc_rel_t                rel;
  svc_clip_t               clip;
  svc_res_t                res;
  logic [NUM_STAGES-1:0]   vld_r, vld_nxt, rdy;

  svc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  assign item = svc_item_t'(in_tdata[$bits(svc_item_t)-1:0]);

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  svc_offset u_offset (
    .clk (clk),
    .en1 (rdy[0]),
    .en2 (rdy[1]),
    .item(item),
    .cfg (cfg),
    .rel (rel)
  );

  svc_clip u_clip (
    .clk (clk),
    .en  (rdy[2]),
    .rel (rel),
    .cfg (cfg),
    .clip(clip)
  );

  svc_index u_index (
    .clk (clk),
    .en4 (rdy[3]),
    .en5 (rdy[4]),
    .clip(clip),
    .cfg (cfg),
    .res (res)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tuser  = res.draw;
  assign out_tdata  = {6'd0, res.dest_index, res.source_index, res.sheet_y, res.sheet_x,
                       res.clip_height, res.clip_width, res.dest_top, res.dest_left};

  a_nodraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("result without draw carries non-zero fields");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off without an output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule
`default_nettype wire

// ===== tb/sprite_viewport_clipper_tb.sv =====
// Self-checking testbench of the sprite viewport clipper: stream stimulus, APB set-up, scoreboard.
`timescale 1ns / 1ps
module sprite_viewport_clipper_tb;
  import svc_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;

  class clip_scoreboard;
    svc_cfg_t    cfg;
    svc_res_t    awaited[$];
    int unsigned errors;

    function new();
      cfg.enable    = 1'b0;
      cfg.origin_x  = '0;
      cfg.origin_y  = '0;
      cfg.vp_width  = VP_WIDTH_RST;
      cfg.vp_height = VP_HEIGHT_RST;
      cfg.camera_x  = '0;
      cfg.camera_y  = '0;
      cfg.pitch     = PITCH_RST;
      errors        = 0;
    endfunction

    function void set_register(svc_reg_t idx, logic [31:0] value);
      case (idx)
        REG_ENABLE:   cfg.enable    = value[0];
        REG_ORIGIN_X: cfg.origin_x  = value[11:0];
        REG_ORIGIN_Y: cfg.origin_y  = value[11:0];
        REG_VP_W:     cfg.vp_width  = value[11:0];
        REG_VP_H:     cfg.vp_height = value[11:0];
        REG_CAMERA_X: cfg.camera_x  = value[15:0];
        REG_CAMERA_Y: cfg.camera_y  = value[15:0];
        REG_PITCH:    cfg.pitch     = value[12:0];
        default: ;
      endcase
    endfunction

    function int s16(logic [15:0] v);
      return int'(signed'(v));
    endfunction

    function bit span(int v, int hi);
      return v >= 0 && v <= hi;
    endfunction

    function svc_res_t clip_sprite(svc_item_t it);
      int q, r, xs, ys, a, b, c, d, ofx, ofy, u, v, w, h;
      bit vis;
      svc_res_t res;
      res = '0;
      if (!cfg.enable) return res;
      q   = cfg.vp_width;
      r   = cfg.vp_height;
      xs  = cfg.origin_x;
      ys  = cfg.origin_y;
      a   = s16(it.world_x - cfg.camera_x);
      b   = s16(it.world_y - cfg.camera_y);
      c   = s16(16'(a + it.frame_width));
      d   = s16(16'(b + it.frame_height));
      ofx = s16(16'(it.frame_column) * 16'(it.frame_width));
      ofy = s16(16'(it.frame_row) * 16'(it.frame_height));
      if ((span(c, q) || span(a, q)) && (b <= 0 && b <= r && d >= 0 && d >= r))
        vis = 1'b1;
      else if ((c >= 0 && c >= q && a <= 0 && a <= q) && (span(b, r) || span(d, r)))
        vis = 1'b1;
      else
        vis = (span(c, q) || span(a, q)) && (span(b, r) || span(d, r));
      if (!vis) return res;
      u = (q + xs) & 'hFFFF;
      v = (r + ys) & 'hFFFF;
      a = s16(16'(a + xs));
      b = s16(16'(b + ys));
      c = s16(16'(c + xs));
      d = s16(16'(d + ys));
      if (a < xs) begin
        ofx = s16(16'(ofx - (a - xs)));
        a   = xs;
      end
      if (b < ys) begin
        ofy = s16(16'(ofy - (b - ys)));
        b   = ys;
      end
      if (c > u) c = u;
      if (d > v) d = v;
      w = s16(16'(c - a));
      h = s16(16'(d - b));
      if (w > 0 && h > 0) begin
        res.draw         = 1'b1;
        res.dest_left    = 16'(a);
        res.dest_top     = 16'(b);
        res.clip_width   = 13'(w);
        res.clip_height  = 13'(h);
        res.sheet_x      = 16'(ofx);
        res.sheet_y      = 16'(ofy);
        res.source_index = res.sheet_x + res.sheet_y * it.sheet_width;
        res.dest_index   = res.dest_top * cfg.pitch + res.dest_left;
      end
      return res;
    endfunction

    function string describe(svc_res_t x);
      return $sformatf("draw=%0d left=%0d top=%0d w=%0d h=%0d sx=%0d sy=%0d src=%0d dst=%0d",
                       x.draw, x.dest_left, x.dest_top, x.clip_width, x.clip_height,
                       x.sheet_x, x.sheet_y, x.source_index, x.dest_index);
    endfunction

    function void fault(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_request(svc_item_t it);
      awaited.push_back(clip_sprite(it));
    endfunction

    function void check_result(logic draw, logic [OUT_DATA_W-1:0] data);
      svc_res_t got, want;
      got.draw         = draw;
      got.dest_left    = data[15:0];
      got.dest_top     = data[31:16];
      got.clip_width   = data[44:32];
      got.clip_height  = data[57:45];
      got.sheet_x      = data[73:58];
      got.sheet_y      = data[89:74];
      got.source_index = data[121:90];
      got.dest_index   = data[153:122];
      if (awaited.size() == 0) begin
        fault({"unexpected result: ", describe(got)});
        return;
      end
      want = awaited.pop_front();
      if (got !== want)
        fault({"mismatch\n  exp ", describe(want), "\n  got ", describe(got)});
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [ADDR_W-1:0]     paddr      = '0;
  logic [31:0]           pwdata     = '0;
  logic [31:0]           prdata;
  logic                  pready;

  clip_scoreboard sb = new();
  int unsigned    items_sent = 0;
  int unsigned    stall_cycles = 0;
  bit             steady = 1'b0;
  bit             squeeze = 1'b0;
  bit             squeezed = 1'b0;

  sprite_viewport_clipper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic write_reg(svc_reg_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [31:0] en, logic [31:0] ox, logic [31:0] oy,
                                logic [31:0] vw, logic [31:0] vh, logic [31:0] cx,
                                logic [31:0] cy, logic [31:0] pitch);
    write_reg(REG_ENABLE, en);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_VP_W, vw);
    write_reg(REG_VP_H, vh);
    write_reg(REG_CAMERA_X, cx);
    write_reg(REG_CAMERA_Y, cy);
    write_reg(REG_PITCH, pitch);
  endtask

  task automatic send_request(svc_item_t it);
    logic [IN_DATA_W-1:0] word;
    if (!steady)
      while ($urandom_range(99) < 11) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    word = '0;
    word[$bits(svc_item_t)-1:0] = it;
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(it);
    items_sent++;
    steady = items_sent >= 900 && items_sent < 1150;
    if (items_sent == 300) squeeze = 1'b1;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic svc_item_t sprite_at(int wx, int wy, int col, int row,
                                          int fw, int fh, int sw);
    svc_item_t it;
    it.world_x      = 16'(wx);
    it.world_y      = 16'(wy);
    it.frame_column = 8'(col);
    it.frame_row    = 8'(row);
    it.frame_width  = 11'(fw);
    it.frame_height = 11'(fh);
    it.sheet_width  = 13'(sw);
    return it;
  endfunction

  function automatic svc_item_t random_sprite();
    logic [95:0] raw;
    int fw, fh, rx, ry;
    if ($urandom_range(9) < 3) begin
      raw = {$urandom(), $urandom(), $urandom()};
      return raw[$bits(svc_item_t)-1:0];
    end
    fw = ($urandom_range(7) == 0) ? $urandom_range(1024, 1) : $urandom_range(64, 1);
    fh = ($urandom_range(7) == 0) ? $urandom_range(1024, 1) : $urandom_range(64, 1);
    rx = int'($urandom_range(sb.cfg.vp_width + 2 * fw + 40)) - fw - 20;
    ry = int'($urandom_range(sb.cfg.vp_height + 2 * fh + 40)) - fh - 20;
    return sprite_at(sb.cfg.camera_x + 16'(rx), sb.cfg.camera_y + 16'(ry),
                     $urandom_range(255), $urandom_range(255), fw, fh,
                     $urandom_range(4096, 1));
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_request(random_sprite());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    run_random(20);

    apply_settings(1, 100, 50, 480, 272, 0, 0, 1024);
    send_request(sprite_at(10, 10, 0, 0, 16, 16, 64));
    send_request(sprite_at(-5, 20, 1, 0, 16, 16, 64));
    send_request(sprite_at(20, -7, 0, 1, 16, 16, 64));
    send_request(sprite_at(470, 100, 2, 3, 16, 16, 128));
    send_request(sprite_at(100, 265, 3, 2, 16, 16, 128));
    send_request(sprite_at(-10, -10, 0, 0, 600, 400, 1024));
    send_request(sprite_at(-100, -100, 7, 9, 1024, 1024, 4096));
    send_request(sprite_at(-10, 100, 0, 0, 600, 16, 1024));
    send_request(sprite_at(100, -10, 0, 0, 16, 400, 1024));
    send_request(sprite_at(-40, 10, 0, 0, 16, 16, 64));
    send_request(sprite_at(500, 10, 0, 0, 16, 16, 64));
    send_request(sprite_at(10, 300, 0, 0, 16, 16, 64));
    send_request(sprite_at(-16, 0, 0, 0, 16, 16, 64));
    send_request(sprite_at(480, 272, 0, 0, 16, 16, 64));
    send_request(sprite_at(32767, 32767, 255, 255, 1024, 1024, 4096));
    send_request(sprite_at(-32768, -32768, 255, 255, 2047, 2047, 8191));
    send_request(sprite_at(0, 0, 0, 0, 0, 0, 0));
    send_request(sprite_at(0, 0, 255, 0, 1, 1, 1));
    send_request(sprite_at(200, 100, 0, 0, 2047, 2047, 8191));
    send_request(sprite_at(-1024, 50, 3, 3, 1024, 8, 4096));
    send_request(sprite_at(-1023, 50, 3, 3, 1024, 8, 4096));
    send_request(sprite_at(470, 262, 255, 255, 1024, 1024, 1));
    drain();

    apply_settings(1, 0, 0, 4095, 4095, 32'h7FFF, 32'h8000, 4096);
    run_random(150);
    apply_settings(1, 4095, 4095, 0, 0, 32'h8000, 32'h7FFF, 1);
    run_random(150);
    apply_settings(1, 4095, 4095, 4095, 4095, 0, 0, 8191);
    run_random(150);
    apply_settings(0, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
    run_random(100);
    repeat (6) begin
      apply_settings(32'hFFFF_FFFF, $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom());
      run_random(200);
    end

    repeat (4 * NUM_STAGES) @(posedge clk);
    sb.errors += sb.awaited.size();
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // hold off once for a long stretch so the pipeline fills and backs up
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
